// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define BDE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BDE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bde_pkg.sv
// Types and constants for the button debounce and encoder speed unit.
package bde_pkg;

  localparam int NUM_BUTTONS = 7;
  localparam int BTN_W       = 7;
  localparam int LANES       = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
  localparam int CNT_W       = 8;
  localparam int ENC_W       = 16;
  localparam int CLK_W       = 15;
  localparam int MAG_W       = 15;
  localparam int SPD_W       = 10;
  localparam int TICK_W      = 32;
  localparam int DIV_W       = 32;
  localparam int DIV_STEP_W  = $clog2(DIV_W);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [BTN_W-1:0]  ACTIVE_RESET   = '0;
  localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = CNT_W'(10);
  localparam logic [DIV_W-1:0]  SPEED_SCALE    = DIV_W'(1000);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_ACTIVE_LEVELS  = 1'b0,
    REG_DEBOUNCE_TICKS = 1'b1
  } reg_idx_t;

  // One classified tick handed from front to back
  typedef struct packed {
    logic [BTN_W-1:0]        states;
    logic [BTN_W-1:0]        changed;
    logic signed [CLK_W-1:0] clicks;
    logic                    moved;
    logic [TICK_W-1:0]       elapsed;
    logic [MAG_W-1:0]        mag;
  } job_t;

  // Request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

// File: rtl/button_debounce_and_encoder_speed_unit.sv
// Button debounce and quadrature encoder speed unit, top level.
// Each input beat is one 1 ms tick carrying raw button levels and the raw 16-bit encoder
// count; each tick yields exactly one result beat, in order. A tick without an encoder
// move is written into the result register as it leaves the job queue; a tick with a move
// goes through the shared 32-step divider, which runs twice (elapsed ms per click, then
// 1000 / ms). A 4-entry job queue lets the front end keep taking ticks while the divider
// works, and a result register holds the oldest result until it is popped. Configuration
// (index 0 active levels, index 1 debounce delay, reset 10) must be written only while no
// tick is in flight; the block itself does not enforce this.
module button_debounce_and_encoder_speed_unit import bde_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [0:0]              wr_index,
  input  logic [CNT_W-1:0]        wr_data,
  input  logic                    push,
  output logic                    full,
  input  logic [BTN_W-1:0]        button_levels,
  input  logic [ENC_W-1:0]        encoder_count,
  output logic                    empty,
  input  logic                    pop,
  output logic [BTN_W-1:0]        button_states,
  output logic [BTN_W-1:0]        changed_mask,
  output logic signed [CLK_W-1:0] click_delta,
  output logic                    moved,
  output logic [SPD_W-1:0]        click_speed
);

`include "assert_macros.svh"

  job_t             front_job, back_job;
  logic             accept, job_empty, job_pop, out_valid, div_done;
  div_req_t         div_req;
  logic [DIV_W-1:0] div_quotient;

  assign accept = push && !full;
  assign empty  = !out_valid;

  bde_front u_front (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .accept        (accept),
    .button_levels (button_levels),
    .encoder_count (encoder_count),
    .job           (front_job)
  );

  bde_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (front_job),
    .full  (full),
    .rd    (job_pop),
    .rdata (back_job),
    .empty (job_empty)
  );

  bde_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  bde_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (back_job),
    .job_empty     (job_empty),
    .job_pop       (job_pop),
    .div_req       (div_req),
    .div_done      (div_done),
    .div_quotient  (div_quotient),
    .pop           (pop),
    .out_valid     (out_valid),
    .button_states (button_states),
    .changed_mask  (changed_mask),
    .click_delta   (click_delta),
    .moved         (moved),
    .click_speed   (click_speed)
  );

  // Checks
  `BDE_ASSERT(a_moved_matches_delta, clk, rst, !empty |-> (moved == (click_delta != '0)), "moved flag disagrees with click delta")
  `BDE_ASSERT(a_speed_in_range, clk, rst, !empty |-> (click_speed <= SPD_W'(1000)), "click speed above 1000")
  `BDE_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> empty, "result present right after reset")

endmodule

// File: rtl/bde_front.sv
// Front end: configuration registers, debounce lanes and encoder click extraction.
module bde_front import bde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [0:0]        wr_index,
  input  logic [CNT_W-1:0]  wr_data,
  input  logic              accept,
  input  logic [BTN_W-1:0]  button_levels,
  input  logic [ENC_W-1:0]  encoder_count,
  output job_t              job
);

  logic [BTN_W-1:0]  active_levels;
  logic [CNT_W-1:0]  debounce_ticks;

  logic [LANES-1:0]  deb_state, deb_state_next;
  logic [LANES-1:0]  cand_state, cand_state_next;
  logic [CNT_W-1:0]  stable_count [LANES];
  logic [CNT_W-1:0]  stable_count_next [LANES];
  logic [BTN_W-1:0]  states_full, changed_full;

  logic [ENC_W-1:0]  consumed, consumed_next;
  logic [TICK_W-1:0] ticks, ticks_inc, ticks_next;
  logic [ENC_W-1:0]  diff, half, clicks16, mag16;
  logic              moved;

  // Per-lane debounce
  always_comb begin
    logic now;
    states_full  = '0;
    changed_full = '0;
    for (int i = 0; i < LANES; i++) begin
      now = (button_levels[i] == active_levels[i]);
      deb_state_next[i]    = deb_state[i];
      cand_state_next[i]   = cand_state[i];
      stable_count_next[i] = stable_count[i];
      if (deb_state[i] != now) begin
        if (cand_state[i] == now && stable_count[i] == debounce_ticks) begin
          deb_state_next[i] = now;
          changed_full[i]   = 1'b1;
        end else if (cand_state[i] == now) begin
          stable_count_next[i] = stable_count[i] + CNT_W'(1);
        end else begin
          cand_state_next[i]   = now;
          stable_count_next[i] = '0;
        end
      end
      states_full[i] = deb_state_next[i];
    end
  end

  // Encoder: wrapped difference halved toward zero
  assign diff          = encoder_count - consumed;
  assign half          = {diff[ENC_W-1], diff[ENC_W-1:1]};
  assign clicks16      = half + ENC_W'(diff[ENC_W-1] & diff[0]);
  assign mag16         = clicks16[ENC_W-1] ? (ENC_W'(0) - clicks16) : clicks16;
  assign moved         = (clicks16 != '0);
  assign consumed_next = consumed + {clicks16[ENC_W-2:0], 1'b0};

  // Elapsed tick counter, saturating
  assign ticks_inc  = (ticks == '1) ? ticks : ticks + TICK_W'(1);
  assign ticks_next = moved ? '0 : ticks_inc;

  always_comb begin
    job.states  = states_full;
    job.changed = changed_full;
    job.clicks  = clicks16[CLK_W-1:0];
    job.moved   = moved;
    job.elapsed = ticks_inc;
    job.mag     = mag16[MAG_W-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels  <= ACTIVE_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_ACTIVE_LEVELS:  active_levels  <= wr_data[BTN_W-1:0];
        REG_DEBOUNCE_TICKS: debounce_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  // Tick state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      deb_state  <= '0;
      cand_state <= '0;
      consumed   <= '0;
      ticks      <= '0;
      for (int i = 0; i < LANES; i++) begin
        stable_count[i] <= '0;
      end
    end else if (accept) begin
      deb_state  <= deb_state_next;
      cand_state <= cand_state_next;
      consumed   <= consumed_next;
      ticks      <= ticks_next;
      for (int i = 0; i < LANES; i++) begin
        stable_count[i] <= stable_count_next[i];
      end
    end
  end

endmodule

// File: rtl/bde_fifo.sv
// Short job queue between the front end and the back end.
module bde_fifo import bde_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wdata,
  output logic full,
  input  logic rd,
  output job_t rdata,
  output logic empty
);

  job_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full  = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (rd && !empty) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if ((wr && !full) && !(rd && !empty)) begin
        count <= count + (FIFO_PTR_W + 1)'(1);
      end else if (!(wr && !full) && (rd && !empty)) begin
        count <= count - (FIFO_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/bde_div.sv
// Shared restoring divider, one quotient bit per cycle.
module bde_div import bde_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [DIV_W-1:0]      rem, divisor;
  logic [DIV_W:0]        trial, sub;

  assign trial = {rem, quotient[DIV_W-1]};
  assign sub   = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '1;
      end else if (busy) begin
        step <= step - DIV_STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      quotient <= req.dividend;
      divisor  <= req.divisor;
    end else if (busy) begin
      if (!sub[DIV_W]) begin
        rem      <= sub[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/bde_back.sv
// Back end: speed computation through the shared divider and the result register.
module bde_back import bde_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  job_t                    job,
  input  logic                    job_empty,
  output logic                    job_pop,
  output div_req_t                div_req,
  input  logic                    div_done,
  input  logic [DIV_W-1:0]        div_quotient,
  input  logic                    pop,
  output logic                    out_valid,
  output logic [BTN_W-1:0]        button_states,
  output logic [BTN_W-1:0]        changed_mask,
  output logic signed [CLK_W-1:0] click_delta,
  output logic                    moved,
  output logic [SPD_W-1:0]        click_speed
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_MS,
    S_DIV_SPEED
  } state_t;

  state_t            state;
  job_t              cur;
  logic [SPD_W-1:0]  held_speed;
  logic              out_free;
  logic              out_load;
  logic              div_start;

  assign out_free = !out_valid || pop;
  assign job_pop  = (state == S_IDLE) && !job_empty && out_free;

  // Result load and divider start for this cycle
  always_comb begin
    out_load  = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        out_load  = job_pop && !job.moved;
        div_start = job_pop && job.moved;
      end
      S_DIV_MS:    div_start = div_done;
      S_DIV_SPEED: out_load  = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      held_speed    <= '0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= div_start;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_pop) begin
            if (job.moved) begin
              // elapsed ms per click first
              cur              <= job;
              div_req.dividend <= job.elapsed;
              div_req.divisor  <= DIV_W'(job.mag);
              state            <= S_DIV_MS;
            end else begin
              button_states <= job.states;
              changed_mask  <= job.changed;
              click_delta   <= job.clicks;
              moved         <= job.moved;
              click_speed   <= held_speed;
            end
          end
        end
        S_DIV_MS: begin
          if (div_done) begin
            // clicks per second, ms clamped to at least one
            div_req.dividend <= SPEED_SCALE;
            div_req.divisor  <= (div_quotient == '0) ? DIV_W'(1) : div_quotient;
            state            <= S_DIV_SPEED;
          end
        end
        S_DIV_SPEED: begin
          if (div_done) begin
            held_speed    <= div_quotient[SPD_W-1:0];
            button_states <= cur.states;
            changed_mask  <= cur.changed;
            click_delta   <= cur.clicks;
            moved         <= cur.moved;
            click_speed   <= div_quotient[SPD_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
